/* sv/tcw_pkg.sv */
// shared types and constants of the text console writer
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int CUR_W = 11;
    localparam int IDX_W = $clog2(CELLS);
    localparam int COL_W = $clog2(COLUMNS);

    localparam logic [7:0] SPACE_CODE   = 8'h20;
    localparam logic [7:0] NEWLINE_CODE = 8'h0A;

    localparam logic [7:0] NORMAL_ATTR_RST    = 8'h0F;
    localparam logic [7:0] ALTERNATE_ATTR_RST = 8'h02;
    localparam logic [7:0] CURSOR_ATTR_RST    = 8'hF0;
    localparam logic [7:0] BLANK_ATTR_RST     = 8'h0F;

    typedef enum logic [2:0] {
        OP_PUT_CHAR = 3'd0,
        OP_DELETE   = 3'd1,
        OP_CLEAR    = 3'd2,
        OP_TOGGLE   = 3'd3,
        OP_READ     = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        REG_NORMAL_ATTR    = 2'd0,
        REG_ALTERNATE_ATTR = 2'd1,
        REG_CURSOR_ATTR    = 2'd2,
        REG_BLANK_ATTR     = 2'd3
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCROLL_MOVE,
        ST_SCROLL_LAST,
        ST_SCROLL_DRAIN,
        ST_PUT,
        ST_MARK,
        ST_DEL_RD,
        ST_DEL_WB,
        ST_READ,
        ST_CLEAR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [7:0] chr;
        logic [7:0] attr;
    } cell_t;

endpackage

`default_nettype wire

/* sv/text_console_writer_core.sv */
// text console writer: screen memory, cursor, color flag and command sequencer
`default_nettype none

// channel   direction  handshake            payload
// s_        in         s_valid / s_ready    s_opcode, s_char_code, s_cell_address
// m_        out        m_valid / m_ready    m_read_char, m_read_attr, m_cursor_cell,
//                                           m_color_alternate
// cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// one word at a time; every write goes through the single write port of the
// screen memory (one cell per cycle). a put char with the cursor past the end
// first scrolls. after reset a clearing pass over all CELLS cells runs before
// s_ready rises.
// a stalled result holds in the output register; a new word is taken meanwhile.

module text_console_writer_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_opcode,
    input  wire logic [7:0]  s_char_code,
    input  wire logic [10:0] s_cell_address,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_read_char,
    output logic [7:0]       m_read_attr,
    output logic [10:0]      m_cursor_cell,
    output logic             m_color_alternate,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    localparam int CUR_W = tcw_pkg::CUR_W;
    localparam int IDX_W = tcw_pkg::IDX_W;
    localparam int COL_W = tcw_pkg::COL_W;
    localparam int CELLS = tcw_pkg::CELLS;
    localparam int COLUMNS = tcw_pkg::COLUMNS;

    tcw_pkg::state_t state_reg, state_next;

    logic [2:0]        op_reg, op_next;
    logic [7:0]        char_reg, char_next;
    logic [10:0]       addr_reg, addr_next;
    logic [CUR_W-1:0]  cursor_reg, cursor_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic              color_reg, color_next;
    logic [IDX_W-1:0]  sweep_reg, sweep_next;
    logic              wb_valid_reg, wb_valid_next;
    logic [IDX_W-1:0]  wb_addr_reg, wb_addr_next;
    logic              wb_blank_reg, wb_blank_next;

    logic [7:0] normal_attr_reg, alternate_attr_reg, cursor_attr_reg, blank_attr_reg;

    logic              m_valid_reg, m_valid_next;
    logic [7:0]        m_char_reg, m_char_next;
    logic [7:0]        m_attr_reg, m_attr_next;
    logic [CUR_W-1:0]  m_cursor_reg, m_cursor_next;
    logic              m_color_reg, m_color_next;

    // screen memory
    tcw_pkg::cell_t    mem [CELLS];
    tcw_pkg::cell_t    mem_rdata;
    tcw_pkg::cell_t    mem_wdata;
    logic              mem_we, mem_re;
    logic [IDX_W-1:0]  mem_waddr, mem_raddr;

    logic              accept;
    logic              cursor_at_end;
    logic              sweep_last;
    logic              out_free;
    logic [COL_W-1:0]  col_inc, col_dec;
    logic [CUR_W-1:0]  cursor_dec;
    logic [7:0]        color_attr;

    assign accept        = s_valid && s_ready;
    assign cursor_at_end = (cursor_reg == CUR_W'(CELLS));
    assign sweep_last    = (sweep_reg == IDX_W'(CELLS - 1));
    assign out_free      = !m_valid_reg || m_ready;
    assign col_inc       = (col_reg == COL_W'(COLUMNS - 1)) ? '0 : col_reg + COL_W'(1);
    assign col_dec       = (col_reg == '0) ? COL_W'(COLUMNS - 1) : col_reg - COL_W'(1);
    assign cursor_dec    = cursor_reg - CUR_W'(1);
    assign color_attr    = color_reg ? alternate_attr_reg : normal_attr_reg;

    assign s_ready           = (state_reg == tcw_pkg::ST_IDLE);
    assign cfg_ready         = 1'b1;
    assign m_valid           = m_valid_reg;
    assign m_read_char       = m_char_reg;
    assign m_read_attr       = m_attr_reg;
    assign m_cursor_cell     = m_cursor_reg;
    assign m_color_alternate = m_color_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            mem_rdata <= mem[mem_raddr];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tcw_pkg::ST_INIT: begin
                if (sweep_last) state_next = tcw_pkg::ST_IDLE;
            end
            tcw_pkg::ST_IDLE: begin
                if (s_valid) begin
                    case (s_opcode)
                        tcw_pkg::OP_PUT_CHAR: begin
                            state_next = cursor_at_end ? tcw_pkg::ST_SCROLL_MOVE
                                                       : tcw_pkg::ST_PUT;
                        end
                        tcw_pkg::OP_DELETE: begin
                            state_next = (cursor_reg == '0) ? tcw_pkg::ST_FINISH
                                                            : tcw_pkg::ST_DEL_RD;
                        end
                        tcw_pkg::OP_CLEAR: state_next = tcw_pkg::ST_CLEAR;
                        tcw_pkg::OP_READ: begin
                            state_next = (s_cell_address < 11'(CELLS)) ? tcw_pkg::ST_READ
                                                                       : tcw_pkg::ST_FINISH;
                        end
                        default: state_next = tcw_pkg::ST_FINISH;
                    endcase
                end
            end
            tcw_pkg::ST_SCROLL_MOVE: begin
                if (sweep_last) state_next = tcw_pkg::ST_SCROLL_LAST;
            end
            tcw_pkg::ST_SCROLL_LAST: begin
                if (sweep_last) state_next = tcw_pkg::ST_SCROLL_DRAIN;
            end
            tcw_pkg::ST_SCROLL_DRAIN: state_next = tcw_pkg::ST_PUT;
            tcw_pkg::ST_PUT: begin
                // newline keeps padding until the cursor wraps to column 0
                if (char_reg != tcw_pkg::NEWLINE_CODE || col_inc == '0) begin
                    state_next = tcw_pkg::ST_MARK;
                end
            end
            tcw_pkg::ST_MARK:   state_next = tcw_pkg::ST_FINISH;
            tcw_pkg::ST_DEL_RD: state_next = tcw_pkg::ST_DEL_WB;
            tcw_pkg::ST_DEL_WB: state_next = tcw_pkg::ST_FINISH;
            tcw_pkg::ST_READ:   state_next = tcw_pkg::ST_FINISH;
            tcw_pkg::ST_CLEAR: begin
                if (sweep_last) state_next = tcw_pkg::ST_FINISH;
            end
            tcw_pkg::ST_FINISH: begin
                if (out_free) state_next = tcw_pkg::ST_IDLE;
            end
            default: state_next = tcw_pkg::ST_INIT;
        endcase
    end

    // memory controls and datapath
    always_comb begin
        op_next       = op_reg;
        char_next     = char_reg;
        addr_next     = addr_reg;
        cursor_next   = cursor_reg;
        col_next      = col_reg;
        color_next    = color_reg;
        sweep_next    = sweep_reg;
        wb_valid_next = 1'b0;
        wb_addr_next  = wb_addr_reg;
        wb_blank_next = wb_blank_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_char_next   = m_char_reg;
        m_attr_next   = m_attr_reg;
        m_cursor_next = m_cursor_reg;
        m_color_next  = m_color_reg;
        mem_we        = 1'b0;
        mem_waddr     = cursor_reg[IDX_W-1:0];
        mem_wdata     = '{chr: tcw_pkg::SPACE_CODE, attr: cursor_attr_reg};
        mem_re        = 1'b0;
        mem_raddr     = cursor_reg[IDX_W-1:0];

        case (state_reg)
            tcw_pkg::ST_INIT: begin
                mem_we     = 1'b1;
                mem_waddr  = sweep_reg;
                mem_wdata  = '{chr: tcw_pkg::SPACE_CODE, attr: tcw_pkg::BLANK_ATTR_RST};
                sweep_next = sweep_last ? '0 : sweep_reg + IDX_W'(1);
            end
            tcw_pkg::ST_IDLE: begin
                if (accept) begin
                    op_next   = s_opcode;
                    char_next = s_char_code;
                    addr_next = s_cell_address;
                    case (s_opcode)
                        tcw_pkg::OP_PUT_CHAR: sweep_next = IDX_W'(COLUMNS);
                        tcw_pkg::OP_CLEAR: begin
                            sweep_next  = '0;
                            cursor_next = '0;
                            col_next    = '0;
                        end
                        tcw_pkg::OP_TOGGLE: color_next = !color_reg;
                        default: ;
                    endcase
                end
            end
            tcw_pkg::ST_SCROLL_MOVE: begin
                // row r+1 read now, written to row r next cycle
                mem_re        = 1'b1;
                mem_raddr     = sweep_reg;
                wb_valid_next = 1'b1;
                wb_addr_next  = sweep_reg - IDX_W'(COLUMNS);
                wb_blank_next = 1'b0;
                mem_we        = wb_valid_reg;
                mem_waddr     = wb_addr_reg;
                mem_wdata     = wb_blank_reg
                              ? tcw_pkg::cell_t'{chr: tcw_pkg::SPACE_CODE,
                                                 attr: mem_rdata.attr}
                              : mem_rdata;
                sweep_next    = sweep_last ? IDX_W'(CELLS - COLUMNS) : sweep_reg + IDX_W'(1);
            end
            tcw_pkg::ST_SCROLL_LAST: begin
                // last row: blank the characters, keep the attributes
                mem_re        = 1'b1;
                mem_raddr     = sweep_reg;
                wb_valid_next = 1'b1;
                wb_addr_next  = sweep_reg;
                wb_blank_next = 1'b1;
                mem_we        = wb_valid_reg;
                mem_waddr     = wb_addr_reg;
                mem_wdata     = wb_blank_reg
                              ? tcw_pkg::cell_t'{chr: tcw_pkg::SPACE_CODE,
                                                 attr: mem_rdata.attr}
                              : mem_rdata;
                sweep_next    = sweep_reg + IDX_W'(1);
            end
            tcw_pkg::ST_SCROLL_DRAIN: begin
                mem_we      = wb_valid_reg;
                mem_waddr   = wb_addr_reg;
                mem_wdata   = '{chr: tcw_pkg::SPACE_CODE, attr: mem_rdata.attr};
                cursor_next = cursor_reg - CUR_W'(COLUMNS);
            end
            tcw_pkg::ST_PUT: begin
                mem_we      = 1'b1;
                mem_waddr   = cursor_reg[IDX_W-1:0];
                mem_wdata   = '{chr: (char_reg == tcw_pkg::NEWLINE_CODE)
                                     ? tcw_pkg::SPACE_CODE : char_reg,
                                attr: color_attr};
                cursor_next = cursor_reg + CUR_W'(1);
                col_next    = col_inc;
            end
            tcw_pkg::ST_MARK: begin
                mem_we    = !cursor_at_end;
                mem_waddr = cursor_reg[IDX_W-1:0];
                mem_wdata = '{chr: tcw_pkg::SPACE_CODE, attr: cursor_attr_reg};
            end
            tcw_pkg::ST_DEL_RD: begin
                mem_we    = 1'b1;
                mem_waddr = cursor_dec[IDX_W-1:0];
                mem_wdata = '{chr: tcw_pkg::SPACE_CODE, attr: cursor_attr_reg};
                mem_re    = !cursor_at_end;
                mem_raddr = cursor_reg[IDX_W-1:0];
            end
            tcw_pkg::ST_DEL_WB: begin
                // old cursor cell keeps its character, takes the blank attribute
                mem_we      = !cursor_at_end;
                mem_waddr   = cursor_reg[IDX_W-1:0];
                mem_wdata   = '{chr: mem_rdata.chr, attr: blank_attr_reg};
                cursor_next = cursor_dec;
                col_next    = col_dec;
            end
            tcw_pkg::ST_READ: begin
                mem_re    = 1'b1;
                mem_raddr = addr_reg[IDX_W-1:0];
            end
            tcw_pkg::ST_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = sweep_reg;
                mem_wdata  = '{chr: tcw_pkg::SPACE_CODE, attr: blank_attr_reg};
                sweep_next = sweep_last ? '0 : sweep_reg + IDX_W'(1);
            end
            tcw_pkg::ST_FINISH: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_cursor_next = cursor_reg;
                    m_color_next  = color_reg;
                    if (op_reg == tcw_pkg::OP_READ && addr_reg < 11'(CELLS)) begin
                        m_char_next = mem_rdata.chr;
                        m_attr_next = mem_rdata.attr;
                    end else begin
                        m_char_next = '0;
                        m_attr_next = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tcw_pkg::ST_INIT;
            cursor_reg   <= '0;
            col_reg      <= '0;
            color_reg    <= 1'b0;
            sweep_reg    <= '0;
            wb_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cursor_reg   <= cursor_next;
            col_reg      <= col_next;
            color_reg    <= color_next;
            sweep_reg    <= sweep_next;
            wb_valid_reg <= wb_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        char_reg     <= char_next;
        addr_reg     <= addr_next;
        wb_addr_reg  <= wb_addr_next;
        wb_blank_reg <= wb_blank_next;
        m_char_reg   <= m_char_next;
        m_attr_reg   <= m_attr_next;
        m_cursor_reg <= m_cursor_next;
        m_color_reg  <= m_color_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            normal_attr_reg    <= tcw_pkg::NORMAL_ATTR_RST;
            alternate_attr_reg <= tcw_pkg::ALTERNATE_ATTR_RST;
            cursor_attr_reg    <= tcw_pkg::CURSOR_ATTR_RST;
            blank_attr_reg     <= tcw_pkg::BLANK_ATTR_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                tcw_pkg::REG_NORMAL_ATTR:    normal_attr_reg    <= cfg_data;
                tcw_pkg::REG_ALTERNATE_ATTR: alternate_attr_reg <= cfg_data;
                tcw_pkg::REG_CURSOR_ATTR:    cursor_attr_reg    <= cfg_data;
                tcw_pkg::REG_BLANK_ATTR:     blank_attr_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // cursor never runs beyond the past-end position
    assert property (@(posedge aclk) disable iff (!aresetn)
        cursor_reg <= CUR_W'(CELLS))
        else $error("cursor beyond screen");

    // every memory write lands inside the screen
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (mem_waddr < IDX_W'(CELLS)))
        else $error("screen write out of range");

    // one word in flight: no accept right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second word accepted while busy");

    // the scroll write-back is always drained before going idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tcw_pkg::ST_IDLE) |-> !wb_valid_reg)
        else $error("pending scroll write in idle");

endmodule

`default_nettype wire
